// ===== rtl/lpcm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED pattern channel mixer package
// Shared constants, types and the level lookup table.
// ----------------------------------------------------------------------------
package lpcm_pkg;

   localparam int LPCM_CHANNELS      = 4;
   localparam int LPCM_PATTERN_DEPTH = 256;

   localparam int DIV_W = 32;

   localparam logic [1:0] OP_TICK  = 2'd0;
   localparam logic [1:0] OP_START = 2'd1;
   localparam logic [1:0] OP_WRITE = 2'd2;

   localparam logic CSR_LED_ENABLE = 1'b0;
   localparam logic CSR_DRIVE_MODE = 1'b1;

   localparam logic [7:0] BINARY_THRESHOLD = 8'd128;

   typedef struct packed {
      logic [31:0] start;
      logic [31:0] period;
      logic [15:0] elem;
      logic [7:0]  loops;
      logic [7:0]  scale;
      logic [7:0]  base;
      logic [6:0]  length;
   } chan_entry_type;

   typedef struct packed {
      logic             go;
      logic [DIV_W-1:0] dividend;
      logic [DIV_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [DIV_W-1:0] quot;
      logic [DIV_W-1:0] rem;
   } div_rsp_type;

   // 6-bit level scaled to 0..255 with rounding
   function automatic logic [63:0][7:0] build_level_table();
      logic [63:0][7:0] t;
      for (int i = 0; i < 64; i++) begin
         t[i] = 8'((i * 255 + 31) / 63);
      end
      return t;
   endfunction

   localparam logic [63:0][7:0] LEVEL_TABLE = build_level_table();

endpackage

// ===== rtl/lpcm_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED pattern channel mixer divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lpcm_div
   import lpcm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);

   localparam int CNT_W = $clog2(DIV_W);

   logic             run_ff, run_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_W-1:0] quot_ff, quot_in;
   logic [DIV_W-1:0] rem_ff, rem_in;
   logic [DIV_W-1:0] den_ff, den_in;
   logic [DIV_W:0]   shifted;
   logic [DIV_W:0]   trial;

   assign shifted = {rem_ff, quot_ff[DIV_W-1]};
   assign trial   = shifted - {1'b0, den_ff};

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quot_in = quot_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (req.go) begin
         run_in  = 1'b1;
         cnt_in  = CNT_W'(DIV_W - 1);
         quot_in = req.dividend;
         rem_in  = '0;
         den_in  = req.divisor;
      end else if (run_ff) begin
         if (!trial[DIV_W]) begin
            rem_in  = trial[DIV_W-1:0];
            quot_in = {quot_ff[DIV_W-2:0], 1'b1};
         end else begin
            rem_in  = shifted[DIV_W-1:0];
            quot_in = {quot_ff[DIV_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == '0) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
   end

   assign rsp.done = done_ff;
   assign rsp.quot = quot_ff;
   assign rsp.rem  = rem_ff;

endmodule

// ===== rtl/lpcm_pat_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED pattern channel mixer pattern memory
// One write port, one registered read port.
// ----------------------------------------------------------------------------
module lpcm_pat_mem
   import lpcm_pkg::*;
#(
   parameter int DEPTH = LPCM_PATTERN_DEPTH,
   parameter int AW    = $clog2(LPCM_PATTERN_DEPTH)
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [7:0]    wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [7:0]    rd_data
);

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/led_pattern_channel_mixer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED pattern channel mixer
// Start and write items are taken while idle and leave the block idle. A
// tick walks the channels one at a time; an active channel waits on the
// shared divider for each divide (loop, element and interpolation). The
// result strobes once, registered from S_DONE after the last channel; busy
// stays high until then and the receiver cannot stall it. Synchronous reset
// clears the active bits, drive mode, last value and strobe, sets LED enable.
// ----------------------------------------------------------------------------
module led_pattern_channel_mixer
   import lpcm_pkg::*;
#(
   parameter int CHANNELS      = LPCM_CHANNELS,
   parameter int PATTERN_DEPTH = LPCM_PATTERN_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_op,
   input  logic [31:0] req_time_ms,
   input  logic [1:0]  req_channel,
   input  logic [7:0]  req_brightness,
   input  logic [7:0]  req_pattern_base,
   input  logic [6:0]  req_pattern_len,
   input  logic [15:0] req_element_time,
   input  logic [7:0]  req_loop_count,
   input  logic [31:0] req_loop_time,
   input  logic [7:0]  req_mem_addr,
   input  logic [7:0]  req_mem_word,
   output logic        rsp_valid,
   output logic [7:0]  rsp_led_value,
   output logic [7:0]  rsp_drive_level,
   output logic        rsp_changed,
   input  logic        csr_wr_en,
   input  logic        csr_index,
   input  logic        csr_wr_data
);

   // Channel index width; pattern depth is a power of two so addresses wrap
   // by dropping upper bits.
   localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int AW = $clog2(PATTERN_DEPTH);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_RD    = 4'd1;
   localparam logic [3:0] S_CHK   = 4'd2;
   localparam logic [3:0] S_DIVP  = 4'd3;
   localparam logic [3:0] S_DIVE  = 4'd4;
   localparam logic [3:0] S_WAIT1 = 4'd5;
   localparam logic [3:0] S_WORD  = 4'd6;
   localparam logic [3:0] S_WAIT2 = 4'd7;
   localparam logic [3:0] S_NEXT  = 4'd8;
   localparam logic [3:0] S_MUL   = 4'd9;
   localparam logic [3:0] S_SUM   = 4'd10;
   localparam logic [3:0] S_DIVI  = 4'd11;
   localparam logic [3:0] S_SCALE = 4'd12;
   localparam logic [3:0] S_FIN   = 4'd13;
   localparam logic [3:0] S_DONE  = 4'd14;

   // Control state
   logic [3:0]          state_ff, state_in;
   logic [CW-1:0]       c_ff, c_in;
   logic [CHANNELS-1:0] active_ff, active_in;
   logic                led_enable_ff;
   logic                drive_mode_ff;
   logic [7:0]          last_ff, last_in;
   logic                rsp_valid_ff, rsp_valid_in;
   div_req_type         div_req_ff, div_req_in;

   // Working data for the channel under evaluation
   logic [31:0]    now_ff, now_in;
   chan_entry_type cur_ff, cur_in;
   logic [31:0]    diff_ff, diff_in;
   logic [6:0]     idx_ff, idx_in;
   logic [15:0]    frac_ff, frac_in;
   logic [7:0]     word_ff, word_in;
   logic [7:0]     val_ff, val_in;
   logic [7:0]     v2_ff, v2_in;
   logic [23:0]    prod_a_ff, prod_a_in;
   logic [23:0]    prod_b_ff, prod_b_in;
   logic [15:0]    sprod_ff, sprod_in;
   logic [7:0]     mix_ff, mix_in;
   logic [AW-1:0]  pat_addr_ff, pat_addr_in;
   logic [7:0]     led_ff, led_in;
   logic [7:0]     drive_ff, drive_in;
   logic           changed_ff, changed_in;

   // Channel memory
   chan_entry_type chan_mem [CHANNELS];
   chan_entry_type chan_rd_ff;
   logic           cwr_en;
   logic [CW-1:0]  cwr_addr;
   chan_entry_type cwr_data;

   // Pattern memory ports
   logic          pwr_en;
   logic [AW-1:0] pwr_addr;
   logic [7:0]    pat_rd;

   div_rsp_type div_rsp;

   logic          accept;
   logic [CW-1:0] start_chan;
   logic [31:0]   mem_addr_wide;
   logic          adv;
   logic          stop;
   logic [15:0]   wfrac;
   logic [15:0]   qsum;
   logic [7:0]    scaled;
   logic [31:0]   addr_sum;

   assign busy   = (state_ff != S_IDLE);
   assign accept = start && !busy;

   // Clamp out-of-range channel numbers to the last channel
   always_comb begin
      if (32'(req_channel) >= CHANNELS) begin
         start_chan = CW'(CHANNELS - 1);
      end else begin
         start_chan = CW'(req_channel);
      end
   end

   assign mem_addr_wide = {24'b0, req_mem_addr};
   assign pwr_en   = accept && (req_op == OP_WRITE);
   assign pwr_addr = mem_addr_wide[AW-1:0];

   lpcm_pat_mem #(
      .DEPTH (PATTERN_DEPTH),
      .AW    (AW)
   ) u_pat_mem (
      .clock   (clock),
      .wr_en   (pwr_en),
      .wr_addr (pwr_addr),
      .wr_data (req_mem_word),
      .rd_addr (pat_addr_ff),
      .rd_data (pat_rd)
   );

   lpcm_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req_ff),
      .rsp   (div_rsp)
   );

   // Helpers for the datapath steps
   assign wfrac    = cur_ff.elem - frac_ff;
   assign qsum     = sprod_ff + 16'd1 + (sprod_ff >> 8);
   assign scaled   = qsum[15:8];
   assign addr_sum = {24'b0, cur_ff.base} + div_rsp.quot;

   // Sequencer: walk the channels, read-modify-write the channel memory
   always_comb begin
      state_in     = state_ff;
      c_in         = c_ff;
      active_in    = active_ff;
      last_in      = last_ff;
      rsp_valid_in = 1'b0;
      div_req_in   = div_req_ff;
      div_req_in.go = 1'b0;
      now_in       = now_ff;
      cur_in       = cur_ff;
      diff_in      = diff_ff;
      idx_in       = idx_ff;
      frac_in      = frac_ff;
      word_in      = word_ff;
      val_in       = val_ff;
      v2_in        = v2_ff;
      prod_a_in    = prod_a_ff;
      prod_b_in    = prod_b_ff;
      sprod_in     = sprod_ff;
      mix_in       = mix_ff;
      pat_addr_in  = pat_addr_ff;
      led_in       = led_ff;
      drive_in     = drive_ff;
      changed_in   = changed_ff;
      cwr_en       = 1'b0;
      cwr_addr     = c_ff;
      cwr_data     = cur_ff;
      adv          = 1'b0;
      stop         = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (accept && (req_op == OP_TICK)) begin
               now_in   = req_time_ms;
               c_in     = '0;
               mix_in   = '0;
               state_in = S_RD;
            end else if (accept && (req_op == OP_START)) begin
               // Load the channel; zero times count as one
               cwr_en          = 1'b1;
               cwr_addr        = start_chan;
               cwr_data.start  = req_time_ms;
               cwr_data.period = (req_loop_time != '0) ? req_loop_time : 32'd1;
               cwr_data.elem   = (req_element_time != '0) ? req_element_time : 16'd1;
               cwr_data.loops  = req_loop_count;
               cwr_data.scale  = req_brightness;
               cwr_data.base   = req_pattern_base;
               cwr_data.length = req_pattern_len;
               active_in[start_chan] = 1'b1;
            end
         end
         S_RD: begin
            state_in = S_CHK;
         end
         S_CHK: begin
            cur_in  = chan_rd_ff;
            diff_in = now_ff - chan_rd_ff.start;
            if (!active_ff[c_ff]) begin
               adv = 1'b1;
            end else if (diff_in >= chan_rd_ff.period) begin
               div_req_in = '{go: 1'b1, dividend: diff_in, divisor: chan_rd_ff.period};
               state_in   = S_DIVP;
            end else begin
               div_req_in = '{go: 1'b1, dividend: diff_in,
                              divisor: {16'b0, chan_rd_ff.elem}};
               state_in   = S_DIVE;
            end
         end
         S_DIVP: begin
            if (div_rsp.done) begin
               if ((cur_ff.loops != '0) && ({24'b0, cur_ff.loops} <= div_rsp.quot)) begin
                  // Loops used up: retire
                  active_in[c_ff] = 1'b0;
                  adv = 1'b1;
               end else begin
                  if (cur_ff.loops != '0) begin
                     cur_in.loops = cur_ff.loops - div_rsp.quot[7:0];
                  end
                  // Drop whole periods: span = diff - remainder
                  cur_in.start = cur_ff.start + (diff_ff - div_rsp.rem);
                  diff_in      = div_rsp.rem;
                  div_req_in   = '{go: 1'b1, dividend: div_rsp.rem,
                                   divisor: {16'b0, cur_ff.elem}};
                  state_in     = S_DIVE;
               end
            end
         end
         S_DIVE: begin
            if (div_rsp.done) begin
               cwr_en = 1'b1;
               if (div_rsp.quot >= {25'b0, cur_ff.length}) begin
                  // Past the pattern end: nothing to add
                  if (cur_ff.loops == 8'd1) begin
                     active_in[c_ff] = 1'b0;
                  end
                  adv = 1'b1;
               end else begin
                  idx_in      = div_rsp.quot[6:0];
                  frac_in     = div_rsp.rem[15:0];
                  pat_addr_in = addr_sum[AW-1:0];
                  state_in    = S_WAIT1;
               end
            end
         end
         S_WAIT1: begin
            state_in = S_WORD;
         end
         S_WORD: begin
            word_in = pat_rd;
            val_in  = LEVEL_TABLE[pat_rd[5:0]];
            if (pat_rd[6] && (({1'b0, idx_ff} + 8'd1) < {1'b0, cur_ff.length})) begin
               pat_addr_in = pat_addr_ff + AW'(1);
               state_in    = S_WAIT2;
            end else begin
               state_in = S_SCALE;
            end
         end
         S_WAIT2: begin
            state_in = S_NEXT;
         end
         S_NEXT: begin
            v2_in    = LEVEL_TABLE[pat_rd[5:0]];
            state_in = S_MUL;
         end
         S_MUL: begin
            prod_a_in = 24'(wfrac) * 24'(val_ff);
            prod_b_in = 24'(frac_ff) * 24'(v2_ff);
            state_in  = S_SUM;
         end
         S_SUM: begin
            div_req_in = '{go: 1'b1,
                           dividend: 32'(prod_a_ff) + 32'(prod_b_ff)
                                     + 32'(cur_ff.elem >> 1),
                           divisor: {16'b0, cur_ff.elem}};
            state_in   = S_DIVI;
         end
         S_DIVI: begin
            if (div_rsp.done) begin
               val_in   = div_rsp.quot[7:0];
               state_in = S_SCALE;
            end
         end
         S_SCALE: begin
            sprod_in = 16'(val_ff) * 16'(cur_ff.scale) + 16'd128;
            state_in = S_FIN;
         end
         S_FIN: begin
            // Divide by 255 through the reciprocal identity
            if (scaled > mix_ff) begin
               mix_in = scaled;
            end
            stop = word_ff[7];
            adv  = 1'b1;
         end
         S_DONE: begin
            led_in     = mix_ff;
            changed_in = (mix_ff != last_ff);
            last_in    = mix_ff;
            if (!led_enable_ff) begin
               drive_in = '0;
            end else if (drive_mode_ff) begin
               drive_in = (mix_ff >= BINARY_THRESHOLD) ? 8'd1 : 8'd0;
            end else begin
               drive_in = mix_ff;
            end
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // Advance to the next channel or finish the walk
      if (adv) begin
         if (stop || (c_ff == CW'(CHANNELS - 1))) begin
            state_in = S_DONE;
         end else begin
            c_in     = c_ff + CW'(1);
            state_in = S_RD;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cwr_en) begin
         chan_mem[cwr_addr] <= cwr_data;
      end
      chan_rd_ff <= chan_mem[c_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         c_ff          <= '0;
         active_ff     <= '0;
         led_enable_ff <= 1'b1;
         drive_mode_ff <= 1'b0;
         last_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
         div_req_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         c_ff         <= c_in;
         active_ff    <= active_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
         div_req_ff   <= div_req_in;
         if (csr_wr_en) begin
            case (csr_index)
               CSR_LED_ENABLE: led_enable_ff <= csr_wr_data;
               CSR_DRIVE_MODE: drive_mode_ff <= csr_wr_data;
               default: ;
            endcase
         end
      end
      now_ff      <= now_in;
      cur_ff      <= cur_in;
      diff_ff     <= diff_in;
      idx_ff      <= idx_in;
      frac_ff     <= frac_in;
      word_ff     <= word_in;
      val_ff      <= val_in;
      v2_ff       <= v2_in;
      prod_a_ff   <= prod_a_in;
      prod_b_ff   <= prod_b_in;
      sprod_ff    <= sprod_in;
      mix_ff      <= mix_in;
      pat_addr_ff <= pat_addr_in;
      led_ff      <= led_in;
      drive_ff    <= drive_in;
      changed_ff  <= changed_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_led_value   = led_ff;
   assign rsp_drive_level = drive_ff;
   assign rsp_changed     = changed_ff;

endmodule

// ===== dv/led_pattern_channel_mixer_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED pattern channel mixer checker
// Watches the item, result and register ports, predicts each tick's mix and
// compares every result, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module led_pattern_channel_mixer_checker
   import lpcm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic [1:0]  req_op,
   input  logic [31:0] req_time_ms,
   input  logic [1:0]  req_channel,
   input  logic [7:0]  req_brightness,
   input  logic [7:0]  req_pattern_base,
   input  logic [6:0]  req_pattern_len,
   input  logic [15:0] req_element_time,
   input  logic [7:0]  req_loop_count,
   input  logic [31:0] req_loop_time,
   input  logic [7:0]  req_mem_addr,
   input  logic [7:0]  req_mem_word,
   input  logic        rsp_valid,
   input  logic [7:0]  rsp_led_value,
   input  logic [7:0]  rsp_drive_level,
   input  logic        rsp_changed,
   input  logic        csr_wr_en,
   input  logic        csr_index,
   input  logic        csr_wr_data,
   output int          fails,
   output int          pending
);

   typedef struct packed {
      logic [7:0] led;
      logic [7:0] drive;
      logic       changed;
   } led_result_type;

   led_result_type mix_q[$];

   bit          enable_q;
   bit          binary_q;
   bit          ch_on[LPCM_CHANNELS];
   bit [31:0]   ch_t0[LPCM_CHANNELS];
   bit [31:0]   ch_loop_ms[LPCM_CHANNELS];
   bit [15:0]   ch_step_ms[LPCM_CHANNELS];
   bit [7:0]    ch_loops[LPCM_CHANNELS];
   bit [7:0]    ch_bright[LPCM_CHANNELS];
   bit [7:0]    ch_first[LPCM_CHANNELS];
   bit [6:0]    ch_words[LPCM_CHANNELS];
   bit [7:0]    words[LPCM_PATTERN_DEPTH];
   bit [7:0]    prev_mix;

   function automatic bit [31:0] level_255(bit [7:0] w);
      return ({26'd0, w[5:0]} * 32'd255 + 32'd31) / 32'd63;
   endfunction

   function automatic bit [7:0] word_at(int c, bit [31:0] idx);
      bit [31:0] a;
      a = ({24'd0, ch_first[c]} + idx) % LPCM_PATTERN_DEPTH;
      return words[a];
   endfunction

   // Play one channel into the running maximum; return 1 to stop the walk.
   function automatic bit play_channel(int c, bit [31:0] now, inout bit [31:0] mix);
      bit [31:0] diff, per, step, idx, done, val, v2, frac;
      bit [7:0]  w;
      if (!ch_on[c]) return 0;
      per  = ch_loop_ms[c];
      diff = now - ch_t0[c];
      if (diff >= per) begin
         done = diff / per;
         if (ch_loops[c] != 0) begin
            if ({24'd0, ch_loops[c]} <= done) begin
               ch_on[c] = 0;
               return 0;
            end
            ch_loops[c] = ch_loops[c] - done[7:0];
         end
         ch_t0[c] = ch_t0[c] + done * per;
         diff     = diff - done * per;
      end
      step = {16'd0, ch_step_ms[c]};
      idx  = diff / step;
      if (idx >= {25'd0, ch_words[c]}) begin
         if (ch_loops[c] == 1) ch_on[c] = 0;
         return 0;
      end
      w   = word_at(c, idx);
      val = level_255(w);
      if (w[6] && idx + 1 < {25'd0, ch_words[c]}) begin
         v2   = level_255(word_at(c, idx + 1));
         frac = diff - idx * step;
         val  = ((step - frac) * val + frac * v2 + step / 2) / step;
      end
      val = (val * ch_bright[c] + 32'd128) / 32'd255;
      if (val > mix) mix = val;
      return w[7];
   endfunction

   always @(posedge clock) begin
      led_result_type exp_r;
      bit [31:0]      mix;
      if (reset) begin
         enable_q = 1;
         binary_q = 0;
         for (int c = 0; c < LPCM_CHANNELS; c++) begin
            ch_on[c] = 0; ch_t0[c] = 0; ch_loop_ms[c] = 0; ch_step_ms[c] = 0;
            ch_loops[c] = 0; ch_bright[c] = 0; ch_first[c] = 0; ch_words[c] = 0;
         end
         prev_mix = 0;
         mix_q.delete();
         fails <= 0;
      end else begin
         if (rsp_valid) begin
            if (mix_q.size() == 0) begin
               if (fails < 10)
                  $display("%0t: result with nothing expected: led %0d drive %0d changed %0d",
                           $realtime, rsp_led_value, rsp_drive_level, rsp_changed);
               fails <= fails + 1;
            end else begin
               exp_r = mix_q.pop_front();
               if (exp_r.led !== rsp_led_value || exp_r.drive !== rsp_drive_level ||
                   exp_r.changed !== rsp_changed) begin
                  if (fails < 10)
                     $display("%0t: led %0d/%0d drive %0d/%0d changed %0d/%0d (exp/act)",
                              $realtime, exp_r.led, rsp_led_value, exp_r.drive,
                              rsp_drive_level, exp_r.changed, rsp_changed);
                  fails <= fails + 1;
               end
            end
         end
         if (csr_wr_en) begin
            if (csr_index == CSR_LED_ENABLE) enable_q = csr_wr_data;
            else                             binary_q = csr_wr_data;
         end
         if (start && !busy) begin
            case (req_op)
               OP_START: begin
                  ch_bright[req_channel]  = req_brightness;
                  ch_first[req_channel]   = req_pattern_base;
                  ch_words[req_channel]   = req_pattern_len;
                  ch_step_ms[req_channel] = (req_element_time == 0) ? 16'd1 : req_element_time;
                  ch_loops[req_channel]   = req_loop_count;
                  ch_loop_ms[req_channel] = (req_loop_time == 0) ? 32'd1 : req_loop_time;
                  ch_t0[req_channel]      = req_time_ms;
                  ch_on[req_channel]      = 1;
               end
               OP_WRITE: words[req_mem_addr] = req_mem_word;
               OP_TICK: begin
                  mix = 0;
                  for (int c = 0; c < LPCM_CHANNELS; c++)
                     if (play_channel(c, req_time_ms, mix)) break;
                  exp_r.led     = mix[7:0];
                  exp_r.drive   = !enable_q ? 8'd0 :
                                  binary_q ? {7'd0, mix[7:0] >= BINARY_THRESHOLD} : mix[7:0];
                  exp_r.changed = (mix[7:0] != prev_mix);
                  prev_mix      = mix[7:0];
                  mix_q.push_back(exp_r);
               end
               default: ;
            endcase
         end
      end
      pending <= mix_q.size();
   end

endmodule

// ===== dv/led_pattern_channel_mixer_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED pattern channel mixer testbench
// Fills the pattern store, runs a directed set of channel starts and ticks,
// then random items under four register settings and sender idle rates.
// The checker beside the block predicts and compares every tick result.
// ----------------------------------------------------------------------------
module led_pattern_channel_mixer_tb;
   import lpcm_pkg::*;

   localparam logic [1:0] OP_NONE = 2'd3;   // unused opcode, ignored by the block

   typedef struct {
      logic [1:0]  op;
      logic [31:0] t;
      logic [1:0]  ch;
      logic [7:0]  bright;
      logic [7:0]  base;
      logic [6:0]  len;
      logic [15:0] step;
      logic [7:0]  loops;
      logic [31:0] loop_ms;
      logic [7:0]  addr;
      logic [7:0]  word;
   } led_item_type;

   logic        clock = 0;
   logic        reset = 1;
   logic        start = 0;
   logic        busy;
   logic [1:0]  req_op = OP_TICK;
   logic [31:0] req_time_ms = 0;
   logic [1:0]  req_channel = 0;
   logic [7:0]  req_brightness = 0;
   logic [7:0]  req_pattern_base = 0;
   logic [6:0]  req_pattern_len = 0;
   logic [15:0] req_element_time = 0;
   logic [7:0]  req_loop_count = 0;
   logic [31:0] req_loop_time = 0;
   logic [7:0]  req_mem_addr = 0;
   logic [7:0]  req_mem_word = 0;
   logic        rsp_valid;
   logic [7:0]  rsp_led_value;
   logic [7:0]  rsp_drive_level;
   logic        rsp_changed;
   logic        csr_wr_en = 0;
   logic        csr_index = 0;
   logic        csr_wr_data = 0;
   int          fails;
   int          pending;

   int          idle_pct;
   logic [31:0] now_ms;

   always #5 clock = ~clock;

   led_pattern_channel_mixer i_dut (.*);

   led_pattern_channel_mixer_checker i_checker (.*);

   // Hold start high across back-to-back items; drop it only for idle gaps.
   task automatic send_item(input led_item_type it);
      while ($urandom_range(99) < idle_pct) begin
         start <= 0;
         @(posedge clock);
      end
      start            <= 1;
      req_op           <= it.op;
      req_time_ms      <= it.t;
      req_channel      <= it.ch;
      req_brightness   <= it.bright;
      req_pattern_base <= it.base;
      req_pattern_len  <= it.len;
      req_element_time <= it.step;
      req_loop_count   <= it.loops;
      req_loop_time    <= it.loop_ms;
      req_mem_addr     <= it.addr;
      req_mem_word     <= it.word;
      do @(posedge clock); while (busy);
   endtask

   // Drop start and wait until every tick result is in and the block rests.
   task automatic drain();
      start <= 0;
      repeat (2) @(posedge clock);
      while (pending != 0 || busy) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // Drop start so the last item is not taken again during the write.
   task automatic write_csr(input logic idx, input logic val);
      start       <= 0;
      csr_wr_en   <= 1;
      csr_index   <= idx;
      csr_wr_data <= val;
      @(posedge clock);
      csr_wr_en   <= 0;
   endtask

   // Random filler everywhere, then the fields that matter for the op.
   function automatic led_item_type noise_item();
      led_item_type it;
      it.op = 2'($urandom); it.t = $urandom; it.ch = 2'($urandom);
      it.bright = 8'($urandom); it.base = 8'($urandom); it.len = 7'($urandom);
      it.step = 16'($urandom); it.loops = 8'($urandom); it.loop_ms = $urandom;
      it.addr = 8'($urandom); it.word = 8'($urandom);
      return it;
   endfunction

   function automatic led_item_type tick_item(input logic [31:0] t);
      led_item_type it;
      it    = noise_item();
      it.op = OP_TICK;
      it.t  = t;
      return it;
   endfunction

   function automatic led_item_type write_item(input logic [7:0] a, input logic [7:0] w);
      led_item_type it;
      it      = noise_item();
      it.op   = OP_WRITE;
      it.addr = a;
      it.word = w;
      return it;
   endfunction

   function automatic led_item_type start_item(input logic [1:0] ch, input logic [31:0] t,
                                               input logic [7:0] bright, input logic [7:0] base,
                                               input logic [6:0] len, input logic [15:0] step,
                                               input logic [7:0] loops, input logic [31:0] lp);
      led_item_type it;
      it         = noise_item();
      it.op      = OP_START;
      it.ch      = ch;      it.t     = t;     it.bright  = bright; it.base = base;
      it.len     = len;     it.step  = step;  it.loops   = loops;  it.loop_ms = lp;
      return it;
   endfunction

   // Mostly sane patterns with moving time, plus noise and odd opcodes.
   task automatic random_phase(input int n);
      led_item_type it;
      int           r;
      logic [6:0]   len;
      logic [15:0]  step;
      for (int k = 0; k < n; k++) begin
         r = $urandom_range(99);
         if (r < 55) begin
            if ($urandom_range(99) < 4) now_ms = $urandom;
            else now_ms = now_ms + $urandom_range(0, 40);
            it = tick_item(now_ms);
         end else if (r < 75) begin
            len  = 7'($urandom_range(1, 16));
            step = 16'($urandom_range(1, 30));
            it = start_item(2'($urandom), now_ms - $urandom_range(0, 20), 8'($urandom),
                            8'($urandom), len, step, 8'($urandom_range(0, 6)),
                            len * step + $urandom_range(0, 60));
         end else if (r < 90) begin
            it = write_item(8'($urandom), 8'($urandom));
         end else if (r < 97) begin
            it = noise_item();
            if (it.op == OP_NONE) it.op = OP_START;
         end else begin
            it    = noise_item();
            it.op = OP_NONE;
         end
         send_item(it);
      end
   endtask

   initial begin
      idle_pct = 0;
      now_ms   = 32'd1000;
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Fill the whole store so no channel ever reads an unwritten word.
      for (int a = 0; a < LPCM_PATTERN_DEPTH; a++)
         send_item(write_item(8'(a), 8'($urandom)));
      send_item(write_item(8'd0, 8'h7F));     // full level, interpolate
      send_item(write_item(8'd1, 8'h00));     // dark
      send_item(write_item(8'd2, 8'hBF));     // full level with interrupt mark
      send_item(write_item(8'd3, 8'h60));     // interpolate on a pattern's last word
      send_item(write_item(8'd255, 8'h3F));   // wrap source at top of store

      // Directed: zero times, interpolation, interrupt, empty and ending patterns.
      write_csr(CSR_LED_ENABLE, 1'b1);
      write_csr(CSR_DRIVE_MODE, 1'b0);
      send_item(start_item(2'd0, 32'd1000, 8'd255, 8'd0, 7'd4, 16'd0, 8'd0, 32'd0));
      send_item(tick_item(32'd1000));
      send_item(start_item(2'd0, 32'd1000, 8'd255, 8'd0, 7'd4, 16'd10, 8'd2, 32'd60));
      send_item(tick_item(32'd1005));           // between word 0 and word 1
      send_item(tick_item(32'd1035));           // last word, no interpolation
      send_item(tick_item(32'd1045));           // past pattern end
      send_item(tick_item(32'd1070));           // second loop
      send_item(tick_item(32'd1200));           // loops used up, retire
      send_item(start_item(2'd1, 32'd1200, 8'd255, 8'd2, 7'd1, 16'hFFFF, 8'd0, 32'hFFFF_FFFF));
      send_item(start_item(2'd3, 32'd1200, 8'd255, 8'd255, 7'd2, 16'd5, 8'd255, 32'd100));
      send_item(tick_item(32'd1201));           // interrupt on channel 1 stops the walk
      send_item(start_item(2'd2, 32'd1200, 8'd0, 8'd255, 7'd0, 16'd1, 8'd1, 32'd10));
      send_item(tick_item(32'd1202));           // channel 1 still stops the walk before the empty pattern
      send_item(start_item(2'd1, 32'd1210, 8'd128, 8'd254, 7'd127, 16'd3, 8'd1, 32'd500));
      send_item(tick_item(32'd1210));
      send_item(tick_item(32'hFFFF_FFFF));      // huge elapsed time
      send_item(noise_item());
      send_item(tick_item(32'd0));              // time wrapped behind every start
      drain();

      now_ms = 32'd5000;
      random_phase(380);
      drain();

      write_csr(CSR_DRIVE_MODE, 1'b1);
      idle_pct = 62;
      random_phase(380);
      drain();

      write_csr(CSR_LED_ENABLE, 1'b0);
      idle_pct = 0;
      now_ms   = 32'hFFFF_F000;                 // run time across the 32-bit wrap
      random_phase(380);
      drain();

      write_csr(CSR_DRIVE_MODE, 1'b0);
      write_csr(CSR_LED_ENABLE, 1'b1);
      idle_pct = 6;
      random_phase(380);
      drain();

      if (fails == 0) $display("SCOREBOARD CLEAN");
      else            $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // Stop a hung run: far beyond the worst tick latency over every item.
   initial begin
      #50ms;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/lpcm_pkg.sv
rtl/lpcm_div.sv
rtl/lpcm_pat_mem.sv
rtl/led_pattern_channel_mixer.sv
dv/led_pattern_channel_mixer_checker.sv
dv/led_pattern_channel_mixer_tb.sv
